FILE: sv/dcrma_pkg.sv
// dcrma_pkg: shared constants, codes and controller/datapath types for the
// dark-corrected ratio moving-average block; no dependencies
package dcrma_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int ENERGY_W    = 20;
    localparam int RATIO_W     = 32;
    localparam int FRAC_BITS   = 24;
    localparam int LEN_REG_W   = 7;
    localparam int OFFSET_W    = 24;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int OUT_TDATA_W = 88;

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_LENGTH = 4'h0;
    localparam logic [APB_ADDR_W-1:0] ADDR_SIGNAL_DARK   = 4'h4;
    localparam logic [APB_ADDR_W-1:0] ADDR_IZERO_DARK    = 4'h8;

    // divisions done per sample, in issue order (the mean ones once the window is full)
    typedef enum logic [2:0] {
        OP_RATIO_A,
        OP_RATIO_B,
        OP_MEAN_E,
        OP_MEAN_A,
        OP_MEAN_B
    } div_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_UPDATE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic    load;
        logic    div_start;
        div_op_t op;
        logic    capture;
        logic    update;
        logic    emit;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic window_full;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: sv/dcrma_ram.sv
// dcrma_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module dcrma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/dcrma_div.sv
// dcrma_div: unsigned restoring divider, one quotient bit per cycle
// no dependencies
module dcrma_div #(
    parameter int DIVIDEND_W = 48,
    parameter int DIVISOR_W  = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CW = $clog2(DIVIDEND_W);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W+1:0]  diff;
    logic                  ge;

    // one restoring step
    always_comb begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = {1'b0, trial} - {2'b00, dvs_reg};
        ge       = !diff[DIVISOR_W+1];
        rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIVIDEND_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operands and partial results
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/dcrma_ctrl.sv
// dcrma_ctrl: sequencer issuing the per-sample divisions, history update
// and result beat; depends on dcrma_pkg
module dcrma_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output dcrma_pkg::dp_cmd_t    cmd,
    input  dcrma_pkg::dp_status_t status
);
    import dcrma_pkg::*;

    ctrl_state_t state_reg, state_next;
    div_op_t     op_reg, op_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_RATIO_A;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.op        = op_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    op_next    = OP_RATIO_A;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                if (status.div_done) begin
                    cmd.capture = 1'b1;
                    case (op_reg)
                        OP_RATIO_A: begin
                            op_next    = OP_RATIO_B;
                            state_next = ST_START;
                        end
                        OP_RATIO_B: state_next = ST_UPDATE;
                        OP_MEAN_E: begin
                            op_next    = OP_MEAN_A;
                            state_next = ST_START;
                        end
                        OP_MEAN_A: begin
                            op_next    = OP_MEAN_B;
                            state_next = ST_START;
                        end
                        OP_MEAN_B: state_next = ST_EMIT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                if (status.window_full) begin
                    op_next    = OP_MEAN_E;
                    state_next = ST_START;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: sv/dcrma_dp.sv
// dcrma_dp: dark correction, ratio saturation, running sums, history RAM
// and output register; depends on dcrma_pkg, dcrma_div, dcrma_ram
module dcrma_dp #(
    parameter int WINDOW_MAX  = dcrma_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = dcrma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  dcrma_pkg::dp_cmd_t                         cmd,
    output dcrma_pkg::dp_status_t                      status,
    input  logic [((dcrma_pkg::ENERGY_W+4*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                       s_tuser,
    input  logic [dcrma_pkg::LEN_REG_W-1:0]            window_length,
    input  logic [dcrma_pkg::OFFSET_W-1:0]             signal_dark_offset,
    input  logic [dcrma_pkg::OFFSET_W-1:0]             izero_dark_offset,
    input  logic                                       restart,
    input  logic                                       m_tready,
    output logic                                       m_tvalid,
    output logic [dcrma_pkg::OUT_TDATA_W-1:0]          m_tdata,
    output logic                                       m_tuser
);
    import dcrma_pkg::*;

    localparam int LW     = $clog2(WINDOW_MAX);
    localparam int LENW   = $clog2(WINDOW_MAX + 1);
    localparam int ESUM_W = ENERGY_W + LW;
    localparam int RSUM_W = RATIO_W + LW;
    localparam int SB     = SAMPLE_BITS;
    localparam int QW     = (SB + FRAC_BITS > RSUM_W) ? SB + FRAC_BITS : RSUM_W;
    localparam int DW     = (SB > LENW) ? SB : LENW;
    localparam int MEM_W  = ENERGY_W + 2 * RATIO_W + 1;

    localparam logic [RATIO_W-1:0] RATIO_MAX = {1'b0, {(RATIO_W-1){1'b1}}};
    localparam logic [RATIO_W-1:0] RATIO_MIN = {1'b1, {(RATIO_W-1){1'b0}}};

    // captured sample
    logic [ENERGY_W-1:0] energy_reg;
    logic [SB-1:0]       sig_a_reg, sig_b_reg, iz_a_reg, iz_b_reg;

    // window state
    logic [ESUM_W-1:0]        e_sum_reg;
    logic signed [RSUM_W-1:0] ra_sum_reg, rb_sum_reg;
    logic [LENW-1:0]          fault_cnt_reg;
    logic [LENW-1:0]          fill_reg;
    logic [LW-1:0]            wp_reg;

    // per-sample results
    logic [RATIO_W-1:0]  ratio_a_reg, ratio_b_reg;
    logic                fault_a_reg, fault_b_reg;
    logic [ENERGY_W-1:0] mean_e_reg;
    logic [RATIO_W-1:0]  mean_a_reg;

    // output beat
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic                   m_user_reg;

    logic [SB:0]     num_a, num_b, den_a, den_b;
    logic [SB-1:0]   num_a_mag, num_b_mag, den_a_mag, den_b_mag;
    logic [LENW-1:0] len;
    int              len_i;
    logic            full_now;
    logic [LENW:0]   fill_inc;
    logic [LW+1:0]   old_sum;
    logic [LW-1:0]   rd_addr;
    logic [LW-1:0]   wp_next;

    logic [QW-1:0]   div_dividend;
    logic [DW-1:0]   div_divisor;
    logic            div_done;
    logic [QW-1:0]   quo;
    logic            res_neg;
    logic            num_neg;
    logic            den_zero;
    logic [RATIO_W-1:0] ratio_val;
    logic [RATIO_W-1:0] quo_neg;

    logic [RSUM_W-1:0] ra_mag, rb_mag;
    logic [MEM_W-1:0]  mem_wdata, mem_rdata;
    logic [ENERGY_W-1:0] old_e;
    logic [RATIO_W-1:0]  old_ra, old_rb;
    logic                old_f;

    // dark correction, sign and magnitude
    always_comb begin
        num_a = {1'b0, sig_a_reg} - {1'b0, SB'(signal_dark_offset)};
        num_b = {1'b0, sig_b_reg} - {1'b0, SB'(signal_dark_offset)};
        den_a = {1'b0, iz_a_reg} - {1'b0, SB'(izero_dark_offset)};
        den_b = {1'b0, iz_b_reg} - {1'b0, SB'(izero_dark_offset)};
        num_a_mag = num_a[SB] ? SB'(-num_a) : num_a[SB-1:0];
        num_b_mag = num_b[SB] ? SB'(-num_b) : num_b[SB-1:0];
        den_a_mag = den_a[SB] ? SB'(-den_a) : den_a[SB-1:0];
        den_b_mag = den_b[SB] ? SB'(-den_b) : den_b[SB-1:0];
        ra_mag = ra_sum_reg[RSUM_W-1] ? RSUM_W'(-ra_sum_reg) : RSUM_W'(ra_sum_reg);
        rb_mag = rb_sum_reg[RSUM_W-1] ? RSUM_W'(-rb_sum_reg) : RSUM_W'(rb_sum_reg);
    end

    // effective window length: zero acts as one, clipped to the history depth
    always_comb begin
        len_i = int'(window_length);
        if (len_i == 0) begin
            len_i = 1;
        end else if (len_i > WINDOW_MAX) begin
            len_i = WINDOW_MAX;
        end
        len      = LENW'(len_i);
        full_now = (fill_reg >= len);
        fill_inc = {1'b0, fill_reg} + 1'b1;
    end

    // oldest entry of the window and next write slot
    always_comb begin
        old_sum = (LW+2)'(wp_reg) + (LW+2)'(WINDOW_MAX) - (LW+2)'(len);
        if (old_sum >= (LW+2)'(WINDOW_MAX)) begin
            old_sum = old_sum - (LW+2)'(WINDOW_MAX);
        end
        rd_addr = old_sum[LW-1:0];
        wp_next = (wp_reg == LW'(WINDOW_MAX - 1)) ? '0 : wp_reg + 1'b1;
    end

    // divider operand selection
    always_comb begin
        div_dividend = '0;
        div_divisor  = '0;
        case (cmd.op)
            OP_RATIO_A: begin
                div_dividend = QW'({num_a_mag, {FRAC_BITS{1'b0}}});
                div_divisor  = DW'(den_a_mag);
            end
            OP_RATIO_B: begin
                div_dividend = QW'({num_b_mag, {FRAC_BITS{1'b0}}});
                div_divisor  = DW'(den_b_mag);
            end
            OP_MEAN_E: begin
                div_dividend = QW'(e_sum_reg);
                div_divisor  = DW'(len);
            end
            OP_MEAN_A: begin
                div_dividend = QW'(ra_mag);
                div_divisor  = DW'(len);
            end
            OP_MEAN_B: begin
                div_dividend = QW'(rb_mag);
                div_divisor  = DW'(len);
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    dcrma_div #(
        .DIVIDEND_W (QW),
        .DIVISOR_W  (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quo)
    );

    // ratio sign, zero-denominator case and saturation
    always_comb begin
        num_neg  = (cmd.op == OP_RATIO_B) ? num_b[SB] : num_a[SB];
        den_zero = (cmd.op == OP_RATIO_B) ? (den_b == '0) : (den_a == '0);
        res_neg  = (cmd.op == OP_RATIO_B) ? (num_b[SB] ^ den_b[SB])
                                          : (num_a[SB] ^ den_a[SB]);
        quo_neg  = RATIO_W'(-quo[RATIO_W-1:0]);
        if (den_zero) begin
            ratio_val = num_neg ? RATIO_MIN : RATIO_MAX;
        end else if (!res_neg) begin
            ratio_val = (|quo[QW-1:RATIO_W-1]) ? RATIO_MAX : quo[RATIO_W-1:0];
        end else if ((|quo[QW-1:RATIO_W]) || (quo[RATIO_W-1] && (|quo[RATIO_W-2:0]))) begin
            ratio_val = RATIO_MIN;
        end else begin
            ratio_val = quo_neg;
        end
    end

    // history memory: energy, both ratios and the fault mark in one word
    assign mem_wdata = {fault_a_reg | fault_b_reg, ratio_b_reg, ratio_a_reg, energy_reg};
    assign old_e  = mem_rdata[ENERGY_W-1:0];
    assign old_ra = mem_rdata[ENERGY_W+RATIO_W-1:ENERGY_W];
    assign old_rb = mem_rdata[ENERGY_W+2*RATIO_W-1:ENERGY_W+RATIO_W];
    assign old_f  = mem_rdata[MEM_W-1];

    dcrma_ram #(
        .WIDTH (MEM_W),
        .DEPTH (WINDOW_MAX)
    ) u_hist (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (wp_reg),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    // sample capture and divider results
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            energy_reg <= s_tdata[ENERGY_W-1:0];
            sig_a_reg  <= s_tdata[ENERGY_W+SB-1:ENERGY_W];
            sig_b_reg  <= s_tdata[ENERGY_W+2*SB-1:ENERGY_W+SB];
            iz_a_reg   <= s_tdata[ENERGY_W+3*SB-1:ENERGY_W+2*SB];
            iz_b_reg   <= s_tdata[ENERGY_W+4*SB-1:ENERGY_W+3*SB];
        end
        if (cmd.capture) begin
            case (cmd.op)
                OP_RATIO_A: begin
                    ratio_a_reg <= ratio_val;
                    fault_a_reg <= den_zero;
                end
                OP_RATIO_B: begin
                    ratio_b_reg <= ratio_val;
                    fault_b_reg <= den_zero;
                end
                OP_MEAN_E: mean_e_reg <= quo[ENERGY_W-1:0];
                OP_MEAN_A: mean_a_reg <= ra_sum_reg[RSUM_W-1] ? quo_neg : quo[RATIO_W-1:0];
                default: begin
                    mean_a_reg <= mean_a_reg;
                end
            endcase
        end
    end

    // running sums, fill count and write pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_sum_reg     <= '0;
            ra_sum_reg    <= '0;
            rb_sum_reg    <= '0;
            fault_cnt_reg <= '0;
            fill_reg      <= '0;
            wp_reg        <= '0;
        end else if (restart || (cmd.load && s_tuser)) begin
            e_sum_reg     <= '0;
            ra_sum_reg    <= '0;
            rb_sum_reg    <= '0;
            fault_cnt_reg <= '0;
            fill_reg      <= '0;
        end else if (cmd.update) begin
            if (full_now) begin
                e_sum_reg     <= e_sum_reg + ESUM_W'(energy_reg) - ESUM_W'(old_e);
                ra_sum_reg    <= ra_sum_reg + RSUM_W'($signed(ratio_a_reg))
                                 - RSUM_W'($signed(old_ra));
                rb_sum_reg    <= rb_sum_reg + RSUM_W'($signed(ratio_b_reg))
                                 - RSUM_W'($signed(old_rb));
                fault_cnt_reg <= fault_cnt_reg + LENW'(fault_a_reg | fault_b_reg)
                                 - LENW'(old_f);
                fill_reg      <= len;
            end else begin
                e_sum_reg     <= e_sum_reg + ESUM_W'(energy_reg);
                ra_sum_reg    <= ra_sum_reg + RSUM_W'($signed(ratio_a_reg));
                rb_sum_reg    <= rb_sum_reg + RSUM_W'($signed(ratio_b_reg));
                fault_cnt_reg <= fault_cnt_reg + LENW'(fault_a_reg | fault_b_reg);
                fill_reg      <= fill_inc[LENW-1:0];
            end
            wp_reg <= wp_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    function automatic logic [RATIO_W-1:0] mean_b_val();
        logic [RATIO_W-1:0] r;
        r = rb_sum_reg[RSUM_W-1] ? quo_neg : quo[RATIO_W-1:0];
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= OUT_TDATA_W'({mean_b_val(), mean_a_reg, mean_e_reg});
            m_user_reg <= (fault_cnt_reg != '0);
        end
    end

    // status back to the sequencer
    always_comb begin
        status.div_done    = div_done;
        status.window_full = full_now || (fill_inc >= {1'b0, len});
        status.out_busy    = m_valid_reg && !m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: sv/dark_corrected_ratio_moving_average.sv
// per sample: two ratio divisions, plus three mean divisions once the window is full,
// on a divider of width Q = max(SAMPLE_BITS+24, 32+log2(WINDOW_MAX)) (48 by default)
// flow: one sample at a time; the single one-bit-per-cycle divider sets the pace
// reset: synchronous, active low; clears sums, fill count, pointer, handshake
// state and registers (window length 1, offsets 0); the history RAM is not cleared
// top level: APB register file, sequencer and datapath; depends on dcrma_pkg, dcrma_ctrl, dcrma_dp
module dark_corrected_ratio_moving_average #(
    parameter int WINDOW_MAX  = dcrma_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = dcrma_pkg::SAMPLE_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    // energy_code, signal_a, signal_b, izero_a, izero_b from bit 0 up
    input  logic [((dcrma_pkg::ENERGY_W+4*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // first_of_scan
    input  logic                                    s_tuser,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // mean_energy, mean_ratio_a, mean_ratio_b from bit 0 up
    output logic [dcrma_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // divide_fault
    output logic                                    m_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [dcrma_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [dcrma_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [dcrma_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                    pready
);
    import dcrma_pkg::*;

    logic [LEN_REG_W-1:0] window_length_reg;
    logic [OFFSET_W-1:0]  signal_dark_reg;
    logic [OFFSET_W-1:0]  izero_dark_reg;
    logic                 restart_reg;
    logic                 wr_en;
    dp_cmd_t              cmd;
    dp_status_t           status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= LEN_REG_W'(1);
            signal_dark_reg   <= '0;
            izero_dark_reg    <= '0;
            restart_reg       <= 1'b0;
        end else begin
            restart_reg <= 1'b0;
            if (wr_en) begin
                case (paddr)
                    ADDR_WINDOW_LENGTH: begin
                        window_length_reg <= pwdata[LEN_REG_W-1:0];
                        restart_reg       <= 1'b1;
                    end
                    ADDR_SIGNAL_DARK: signal_dark_reg <= pwdata[OFFSET_W-1:0];
                    ADDR_IZERO_DARK:  izero_dark_reg  <= pwdata[OFFSET_W-1:0];
                    default:          restart_reg     <= 1'b0;
                endcase
            end
        end
    end

    // read-back
    always_comb begin
        case (paddr)
            ADDR_WINDOW_LENGTH: prdata = APB_DATA_W'(window_length_reg);
            ADDR_SIGNAL_DARK:   prdata = APB_DATA_W'(signal_dark_reg);
            ADDR_IZERO_DARK:    prdata = APB_DATA_W'(izero_dark_reg);
            default:            prdata = '0;
        endcase
    end

    dcrma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    dcrma_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_tdata            (s_tdata),
        .s_tuser            (s_tuser),
        .window_length      (window_length_reg),
        .signal_dark_offset (signal_dark_reg),
        .izero_dark_offset  (izero_dark_reg),
        .restart            (restart_reg),
        .m_tready           (m_tready),
        .m_tvalid           (m_tvalid),
        .m_tdata            (m_tdata),
        .m_tuser            (m_tuser)
    );

endmodule

FILE: sv/dcrma_checker.sv
// dcrma_checker: port-level assertions for the ratio moving-average block
// bound to the top level below; depends on dcrma_pkg
module dcrma_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [dcrma_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                              m_tuser,
    input logic                              pready
);
    import dcrma_pkg::*;

    // no result beat straight after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // one sample at a time: busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready straight after an accepted beat");

    // config port never stalls
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

    // stalled result beat stays
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("result beat changed while stalled");

endmodule

bind dark_corrected_ratio_moving_average dcrma_checker u_dcrma_checker (.*);

FILE: tb/dark_corrected_ratio_moving_average_tb.sv
// testbench for the dark-corrected ratio moving-average block: self-checking,
// random and directed samples over several register settings
// depends on dcrma_pkg and dark_corrected_ratio_moving_average
module dark_corrected_ratio_moving_average_tb;
    import dcrma_pkg::*;

    localparam int IN_TDATA_W = ((ENERGY_W + 4*SAMPLE_BITS_DEF + 7)/8)*8;
    localparam int HIST_DEPTH = WINDOW_MAX_DEF;
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        logic [ENERGY_W-1:0] energy;
        logic [23:0]         sig_a;
        logic [23:0]         sig_b;
        logic [23:0]         iz_a;
        logic [23:0]         iz_b;
        logic                first_of_scan;
    } sample_t;

    typedef struct {
        logic [ENERGY_W-1:0] mean_energy;
        logic [RATIO_W-1:0]  mean_ratio_a;
        logic [RATIO_W-1:0]  mean_ratio_b;
        logic                divide_fault;
    } mean_t;

    // predicts window means from accepted samples and checks output beats
    class mean_scoreboard;
        mean_t               pending_means[$];
        int                  errors;
        logic [LEN_REG_W-1:0] len_reg;
        logic [23:0]         sig_dark;
        logic [23:0]         iz_dark;
        logic [ENERGY_W-1:0] e_hist[HIST_DEPTH];
        logic [RATIO_W-1:0]  a_hist[HIST_DEPTH];
        logic [RATIO_W-1:0]  b_hist[HIST_DEPTH];
        bit                  f_hist[HIST_DEPTH];
        longint              e_sum, a_sum, b_sum;
        int                  f_count, wr_ptr, fill;

        function new();
            errors = 0;
            len_reg = LEN_REG_W'(1);
            sig_dark = '0;
            iz_dark = '0;
            wr_ptr = 0;
            clear_window();
        endfunction

        function void clear_window();
            e_sum = 0;
            a_sum = 0;
            b_sum = 0;
            f_count = 0;
            fill = 0;
        endfunction

        function void set_register(logic [APB_ADDR_W-1:0] addr, logic [31:0] value);
            case (addr)
                ADDR_WINDOW_LENGTH: begin
                    len_reg = value[LEN_REG_W-1:0];
                    clear_window();
                end
                ADDR_SIGNAL_DARK: sig_dark = value[23:0];
                ADDR_IZERO_DARK:  iz_dark = value[23:0];
                default: ;
            endcase
        endfunction

        // dark-corrected Q8.24 quotient with saturation
        function logic [RATIO_W-1:0] ratio(logic [23:0] s, logic [23:0] i, output bit flt);
            longint num, den, q;
            num = longint'(s);
            num = num - longint'(sig_dark);
            den = longint'(i);
            den = den - longint'(iz_dark);
            if (den == 0) begin
                flt = 1;
                return (num >= 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            flt = 0;
            q = (num * 64'sd16777216) / den;
            if (q > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (q < -64'sd2147483648) return 32'h8000_0000;
            return q[31:0];
        endfunction

        function void note_sample(sample_t smp);
            int len, old;
            bit fa, fb;
            logic [RATIO_W-1:0] ra, rb;
            mean_t m;
            longint qe, qa, qb;
            len = (len_reg == 0) ? 1 : ((len_reg > HIST_DEPTH) ? HIST_DEPTH : int'(len_reg));
            ra = ratio(smp.sig_a, smp.iz_a, fa);
            rb = ratio(smp.sig_b, smp.iz_b, fb);
            if (smp.first_of_scan) clear_window();
            if (fill >= len) begin
                old = (wr_ptr + HIST_DEPTH - len) % HIST_DEPTH;
                e_sum -= longint'(e_hist[old]);
                a_sum -= longint'($signed(a_hist[old]));
                b_sum -= longint'($signed(b_hist[old]));
                f_count -= f_hist[old];
                fill = len;
            end else begin
                fill++;
            end
            e_hist[wr_ptr] = smp.energy;
            a_hist[wr_ptr] = ra;
            b_hist[wr_ptr] = rb;
            f_hist[wr_ptr] = fa | fb;
            e_sum += longint'(smp.energy);
            a_sum += longint'($signed(ra));
            b_sum += longint'($signed(rb));
            f_count += (fa | fb);
            wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
            if (fill < len) return;
            qe = e_sum / longint'(len);
            qa = a_sum / longint'(len);
            qb = b_sum / longint'(len);
            m.mean_energy = qe[ENERGY_W-1:0];
            m.mean_ratio_a = qa[RATIO_W-1:0];
            m.mean_ratio_b = qb[RATIO_W-1:0];
            m.divide_fault = (f_count != 0);
            pending_means.push_back(m);
        endfunction

        function void report(string what, mean_t exp_m, mean_t got);
            errors++;
            if (errors <= 10)
                $display("mismatch %s: exp e=%h a=%h b=%h f=%b got e=%h a=%h b=%h f=%b",
                         what, exp_m.mean_energy, exp_m.mean_ratio_a, exp_m.mean_ratio_b,
                         exp_m.divide_fault, got.mean_energy, got.mean_ratio_a,
                         got.mean_ratio_b, got.divide_fault);
        endfunction

        function void check_result(mean_t got);
            mean_t exp_m;
            if (pending_means.size() == 0) begin
                exp_m = '{default: '0};
                report("unexpected beat", exp_m, got);
                return;
            end
            exp_m = pending_means.pop_front();
            if (got.mean_energy !== exp_m.mean_energy ||
                got.mean_ratio_a !== exp_m.mean_ratio_a ||
                got.mean_ratio_b !== exp_m.mean_ratio_b ||
                got.divide_fault !== exp_m.divide_fault)
                report("field", exp_m, got);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic                  s_tuser, s_tvalid, s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                  m_tuser, m_tvalid, m_tready;
    logic                  psel, penable, pwrite, pready;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata, prdata;

    mean_scoreboard sb;
    bit hold_req;
    int burst_left;

    dark_corrected_ratio_moving_average dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    initial aclk = 0;
    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // output monitor
    always @(posedge aclk) begin
        mean_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.mean_energy = m_tdata[19:0];
            got.mean_ratio_a = m_tdata[51:20];
            got.mean_ratio_b = m_tdata[83:52];
            got.divide_fault = m_tuser;
            sb.check_result(got);
        end
    end

    // receiver: stall pattern in randomly switched modes, plus a long hold on request
    initial begin
        int mode;
        m_tready <= 1'b0;
        mode = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // run ends here if the block hangs
    initial begin
        #(8 * 4_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_register(addr, value);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // one beat, with burst and gap handling afterwards
    task automatic send_sample(sample_t smp);
        int gap;
        s_tdata <= {4'b0, smp.iz_b, smp.iz_a, smp.sig_b, smp.sig_a, smp.energy};
        s_tuser <= smp.first_of_scan;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(smp);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 40);
            burst_left = $urandom_range(0, 30);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // current with bias towards the dark level and the range ends
    function automatic logic [23:0] pick_current(logic [23:0] dark);
        logic [31:0] r;
        case ($urandom_range(0, 9))
            0: return dark;
            1: begin
                r = 32'(dark) + $urandom_range(0, 3) - 32'd1;
                return r[23:0];
            end
            2: return 24'hFF_FFFF;
            3: return 24'h0;
            4: begin
                r = $urandom_range(0, 4095);
                return r[23:0];
            end
            default: begin
                r = $urandom();
                return r[23:0];
            end
        endcase
    endfunction

    function automatic sample_t random_sample(logic [23:0] sd, logic [23:0] id);
        sample_t smp;
        logic [31:0] r;
        r = $urandom();
        smp.energy = r[ENERGY_W-1:0];
        smp.sig_a = pick_current(sd);
        smp.sig_b = pick_current(sd);
        smp.iz_a = pick_current(id);
        smp.iz_b = pick_current(id);
        smp.first_of_scan = ($urandom_range(0, 39) == 0);
        return smp;
    endfunction

    // stop offering, then wait for every expected beat and the last sample
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_means.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(logic [31:0] len, logic [31:0] sd, logic [31:0] id);
        apb_write(ADDR_WINDOW_LENGTH, len);
        apb_write(ADDR_SIGNAL_DARK, sd);
        apb_write(ADDR_IZERO_DARK, id);
    endtask

    function automatic sample_t mk(logic [19:0] e, logic [23:0] sa, logic [23:0] sbv,
                                   logic [23:0] ia, logic [23:0] ib, logic fos);
        sample_t smp;
        smp.energy = e;
        smp.sig_a = sa;
        smp.sig_b = sbv;
        smp.iz_a = ia;
        smp.iz_b = ib;
        smp.first_of_scan = fos;
        return smp;
    endfunction

    // main sequence
    initial begin
        logic [31:0] lens[7];
        logic [31:0] sdarks[7];
        logic [31:0] idarks[7];
        sb = new();
        hold_req = 0;
        burst_left = 0;
        aresetn <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        s_tvalid <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: dark levels 1000 / 500, window of two
        set_config(2, 1000, 500);
        send_sample(mk(20'h0, 24'd1000, 24'd2000, 24'd500, 24'd1500, 1'b0));
        send_sample(mk(20'hF_FFFF, 24'd0, 24'hFF_FFFF, 24'd500, 24'd500, 1'b0));
        send_sample(mk(20'hF_FFFF, 24'hFF_FFFF, 24'd0, 24'd501, 24'd499, 1'b0));
        send_sample(mk(20'h1_2345, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 1'b1));
        send_sample(mk(20'h5_4321, 24'd999, 24'd1001, 24'd0, 24'hFF_FFFF, 1'b0));
        send_sample(mk(20'hA_AAAA, 24'hAA_AAAA, 24'h55_5555, 24'h55_5555, 24'hAA_AAAA, 1'b0));
        send_sample(mk(20'h5_5555, 24'h55_5555, 24'hAA_AAAA, 24'hAA_AAAA, 24'h55_5555, 1'b1));
        send_sample(mk(20'h0_0001, 24'd1000, 24'd1000, 24'd501, 24'd501, 1'b0));
        send_sample(mk(20'h8_0000, 24'd1001, 24'd999, 24'd1500, 24'd1500, 1'b1));
        drain();
        // zero and over-range lengths, extreme dark levels
        set_config(0, 0, 24'hFF_FFFF);
        send_sample(mk(20'h1, 24'hFF_FFFF, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF, 1'b0));
        send_sample(mk(20'h2, 24'd0, 24'd0, 24'd0, 24'hFF_FFFE, 1'b0));
        drain();
        set_config(127, 24'hFF_FFFF, 0);
        repeat (70) send_sample(random_sample(24'hFF_FFFF, 0));
        drain();

        // random phases
        lens = '{1, 64, 3, 8, 65, 16, 5};
        sdarks = '{0, 24'hFF_FFFF, $urandom(), 24'h100, $urandom(), 0, 24'h7F_FFFF};
        idarks = '{0, 24'hFF_FFFF, $urandom(), 24'h10, 0, $urandom(), 24'h80_0000};
        for (int p = 0; p < 7; p++) begin
            set_config(lens[p], sdarks[p], idarks[p]);
            for (int n = 0; n < 100; n++) begin
                if (p == 2 && n == 30) hold_req = 1;
                send_sample(random_sample(sdarks[p][23:0], idarks[p][23:0]));
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending_means.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

FILE: filelist.f
sv/dcrma_pkg.sv
sv/dcrma_ram.sv
sv/dcrma_div.sv
sv/dcrma_ctrl.sv
sv/dcrma_dp.sv
sv/dark_corrected_ratio_moving_average.sv
sv/dcrma_checker.sv
tb/dark_corrected_ratio_moving_average_tb.sv
